/* src/efv_pkg.sv */
`default_nettype none

package efv_pkg;

  // Frame limits
  localparam int MAX_FRAME = 8192;
  localparam int MAX_TEXT  = 1024;

  localparam int BC_W  = $clog2(MAX_FRAME + 2);   // counts up to MAX_FRAME+1
  localparam int REM_W = $clog2(MAX_TEXT + 1);

  localparam logic [31:0] MAGIC_WORD = 32'h4341_5846;

  // Layout sequencer
  localparam int STEP_W = 5;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_MAGIC = step_t'(0);
  localparam step_t STEP_T1    = step_t'(8);
  localparam step_t STEP_T3    = step_t'(11);
  localparam step_t STEP_T5    = step_t'(12);
  localparam step_t STEP_T6    = step_t'(17);
  localparam step_t STEP_END   = step_t'(27);

  typedef enum logic [3:0] {
    K_PLAIN, K_MAGIC, K_VER, K_TYPE, K_DISPATCH,
    K_ACTION, K_FACE, K_FLAG, K_TEXT, K_S32
  } kind_t;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_OVERSIZE  = 4'd1,
    ST_TRUNCATED = 4'd2,
    ST_SCHEMA    = 4'd3,
    ST_UNK_TYPE  = 4'd4,
    ST_BAD_LEN   = 4'd5,
    ST_NON_ASCII = 4'd6,
    ST_BAD_ENUM  = 4'd7,
    ST_BAD_FLAG  = 4'd8,
    ST_TRAILING  = 4'd9
  } status_t;

  typedef struct packed {
    logic        kind;      // 0 field, 1 verdict
    logic [4:0]  idx;
    logic [63:0] value;
    status_t     status;
    logic [15:0] etype;
    logic        last;
  } res_t;

  // Result queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [3:0] size;
    kind_t      kind;
    step_t      next;
  } step_desc_t;

  function automatic step_desc_t lay_desc(input step_t s);
    step_desc_t d;
    d = '{size: 4'd8, kind: K_PLAIN, next: STEP_END};
    unique case (s)
      5'd0:  d = '{4'd4, K_MAGIC,    step_t'(1)};
      5'd1:  d = '{4'd2, K_VER,      step_t'(2)};
      5'd2:  d = '{4'd2, K_TYPE,     step_t'(3)};
      5'd3:  d = '{4'd8, K_PLAIN,    step_t'(4)};
      5'd4:  d = '{4'd8, K_PLAIN,    step_t'(5)};
      5'd5:  d = '{4'd8, K_PLAIN,    step_t'(6)};
      5'd6:  d = '{4'd8, K_PLAIN,    step_t'(7)};
      5'd7:  d = '{4'd8, K_DISPATCH, STEP_END};
      5'd8:  d = '{4'd2, K_TEXT,     step_t'(9)};
      5'd9:  d = '{4'd4, K_PLAIN,    step_t'(10)};
      5'd10: d = '{4'd4, K_PLAIN,    STEP_END};
      5'd11: d = '{4'd2, K_TEXT,     STEP_END};
      5'd12: d = '{4'd8, K_PLAIN,    step_t'(13)};
      5'd13: d = '{4'd8, K_PLAIN,    step_t'(14)};
      5'd14: d = '{4'd8, K_PLAIN,    step_t'(15)};
      5'd15: d = '{4'd1, K_ACTION,   step_t'(16)};
      5'd16: d = '{4'd1, K_FACE,     step_t'(17)};
      5'd17: d = '{4'd4, K_S32,      step_t'(18)};
      5'd18: d = '{4'd4, K_S32,      step_t'(19)};
      5'd19: d = '{4'd4, K_S32,      step_t'(20)};
      5'd20: d = '{4'd2, K_TEXT,     step_t'(21)};
      5'd21: d = '{4'd2, K_TEXT,     step_t'(22)};
      5'd22: d = '{4'd2, K_TEXT,     step_t'(23)};
      5'd23: d = '{4'd2, K_TEXT,     step_t'(24)};
      5'd24: d = '{4'd2, K_TEXT,     step_t'(25)};
      5'd25: d = '{4'd8, K_PLAIN,    step_t'(26)};
      5'd26: d = '{4'd1, K_FLAG,     STEP_END};
      default: d = '{4'd8, K_PLAIN,  STEP_END};
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

/* src/event_frame_validator.sv */
`default_nettype none

// A field or verdict is written to the result queue when its byte is taken and offered on m_axis from there.
// Throughput: one byte per cycle; the frame's last byte may yield two results, drained
// one per cycle while m_axis_tready is high from a 4-entry result queue, so s_axis_tready
// drops only while the queue holds more than two entries.
// Reset (rst, synchronous): clears the layout sequencer, error latch and counters,
// and empties the result queue; the first byte after reset is a magic byte.

module event_frame_validator
  import efv_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,

  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tlast,   // frame_last

  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [95:0]      m_axis_tdata,   // [4:0] field_index, [68:5] field_value,
                                           // [72:69] status, [88:73] event_type, rest 0
  output logic             m_axis_tuser,   // item_kind
  output logic             m_axis_tlast    // run_last
);

  // ---------------------------------------------------------------------------
  // Frame state
  // ---------------------------------------------------------------------------
  logic [BC_W-1:0]  byte_count,     byte_count_next;
  step_t            layout_step,    layout_step_next;
  logic [63:0]      field_accum,    field_accum_next;
  logic [2:0]       field_byte,     field_byte_next;
  logic [REM_W-1:0] text_remaining, text_remaining_next;
  logic             in_text,        in_text_next;
  logic [15:0]      type_reg,       type_reg_next;
  logic [1:0]       action_reg,     action_reg_next;
  status_t          error_latch,    error_latch_next;
  logic [4:0]       field_count,    field_count_next;

  logic accept;
  assign accept = s_axis_tvalid && s_axis_tready;

  // One pass of the layout walker per request
  logic        emit_field;
  logic [63:0] emit_value;
  status_t     verdict;

  always_comb begin
    step_desc_t  d;
    logic [63:0] acc;
    logic [3:0]  fb_inc;
    step_t       nxt;
    logic [7:0]  b;

    b                   = s_axis_tdata;
    d                   = lay_desc(layout_step);
    acc                 = field_accum | (64'(b) << {field_byte, 3'b000});
    fb_inc              = {1'b0, field_byte} + 4'd1;
    nxt                 = d.next;

    byte_count_next     = byte_count;
    layout_step_next    = layout_step;
    field_accum_next    = field_accum;
    field_byte_next     = field_byte;
    text_remaining_next = text_remaining;
    in_text_next        = in_text;
    type_reg_next       = type_reg;
    action_reg_next     = action_reg;
    error_latch_next    = error_latch;
    field_count_next    = field_count;
    emit_field          = 1'b0;
    emit_value          = acc;
    verdict             = ST_OK;

    if (byte_count <= BC_W'(MAX_FRAME)) begin
      byte_count_next = byte_count + BC_W'(1);
    end

    if (error_latch == ST_OK) begin
      if (layout_step >= STEP_END) begin
        error_latch_next = ST_TRAILING;
      end else if (in_text) begin
        if (b < 8'd32 || b > 8'd126) begin
          error_latch_next = ST_NON_ASCII;
        end
        text_remaining_next = text_remaining - REM_W'(1);
        if (text_remaining == REM_W'(1)) begin
          in_text_next = 1'b0;
        end
      end else if (fb_inc >= d.size) begin
        emit_field = 1'b1;
        case (d.kind)
          K_MAGIC: begin
            if (acc[31:0] != MAGIC_WORD) error_latch_next = ST_SCHEMA;
          end
          K_VER: begin
            if (acc[15:0] != 16'd1) error_latch_next = ST_SCHEMA;
          end
          K_TYPE: begin
            type_reg_next = acc[15:0];
          end
          K_DISPATCH: begin
            case (type_reg)
              16'd1:   nxt = STEP_T1;
              16'd2:   nxt = STEP_END;
              16'd3:   nxt = STEP_T3;
              16'd4:   nxt = STEP_END;
              16'd5:   nxt = STEP_T5;
              16'd6:   nxt = STEP_T6;
              default: error_latch_next = ST_UNK_TYPE;
            endcase
          end
          K_ACTION: begin
            action_reg_next = (acc[7:0] > 8'd2) ? 2'd3 : acc[1:0];
          end
          K_FACE: begin
            if (action_reg == 2'd3 || acc[7:0] > 8'd5) error_latch_next = ST_BAD_ENUM;
          end
          K_FLAG: begin
            if (acc[7:0] > 8'd1) error_latch_next = ST_BAD_FLAG;
          end
          K_TEXT: begin
            if (acc[15:0] > 16'(MAX_TEXT)) begin
              error_latch_next = ST_BAD_LEN;
            end else if (acc[15:0] != 16'd0) begin
              in_text_next        = 1'b1;
              text_remaining_next = acc[REM_W-1:0];
            end
          end
          K_S32: begin
            emit_value = {{32{acc[31]}}, acc[31:0]};
          end
          default: ;
        endcase
        if (error_latch_next == ST_OK) begin
          layout_step_next = nxt;
        end
        field_count_next = field_count + 5'd1;
        field_accum_next = '0;
        field_byte_next  = '0;
      end else begin
        field_accum_next = acc;
        field_byte_next  = fb_inc[2:0];
      end
    end else if (in_text) begin
      // Error already latched: keep counting the body for the length rule
      text_remaining_next = text_remaining - REM_W'(1);
      if (text_remaining == REM_W'(1)) begin
        in_text_next = 1'b0;
      end
    end

    // Verdict priority: oversize, open text body, latched error, short layout
    if (byte_count_next > BC_W'(MAX_FRAME)) begin
      verdict = ST_OVERSIZE;
    end else if (in_text_next) begin
      verdict = ST_BAD_LEN;
    end else if (error_latch_next != ST_OK) begin
      verdict = error_latch_next;
    end else if (layout_step_next < STEP_END) begin
      verdict = ST_TRUNCATED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && s_axis_tlast)) begin
      byte_count     <= '0;
      layout_step    <= STEP_MAGIC;
      field_accum    <= '0;
      field_byte     <= '0;
      text_remaining <= '0;
      in_text        <= 1'b0;
      type_reg       <= '0;
      action_reg     <= '0;
      error_latch    <= ST_OK;
      field_count    <= '0;
    end else if (accept) begin
      byte_count     <= byte_count_next;
      layout_step    <= layout_step_next;
      field_accum    <= field_accum_next;
      field_byte     <= field_byte_next;
      text_remaining <= text_remaining_next;
      in_text        <= in_text_next;
      type_reg       <= type_reg_next;
      action_reg     <= action_reg_next;
      error_latch    <= error_latch_next;
      field_count    <= field_count_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Results of this request: a field, a verdict, or a field then a verdict
  // ---------------------------------------------------------------------------
  res_t res_field, res_verdict, res_first;
  logic push_two, push_one;

  always_comb begin
    res_field   = '{kind: 1'b0, idx: field_count, value: emit_value, status: ST_OK,
                    etype: 16'd0, last: !s_axis_tlast};
    res_verdict = '{kind: 1'b1, idx: 5'd0, value: 64'd0, status: verdict,
                    etype: type_reg_next, last: 1'b1};
    res_first   = emit_field ? res_field : res_verdict;
    push_two    = accept && emit_field && s_axis_tlast;
    push_one    = accept && (emit_field || s_axis_tlast) && !push_two;
  end

  // ---------------------------------------------------------------------------
  // Result queue: up to two writes, one read per cycle
  // ---------------------------------------------------------------------------
  res_t              q_mem [QDEPTH];
  logic [QPTR_W-1:0] q_wr, q_rd;
  logic [QCNT_W-1:0] q_cnt, q_cnt_next;
  logic              pop;
  res_t              head;

  assign pop           = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (q_cnt <= QCNT_W'(QDEPTH - 2));
  assign m_axis_tvalid = (q_cnt != '0);

  always_comb begin
    q_cnt_next = q_cnt - QCNT_W'(pop);
    if (push_two) begin
      q_cnt_next = q_cnt_next + QCNT_W'(2);
    end else if (push_one) begin
      q_cnt_next = q_cnt_next + QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push_one || push_two) begin
      q_mem[q_wr] <= res_first;
    end
    if (push_two) begin
      q_mem[q_wr + QPTR_W'(1)] <= res_verdict;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wr  <= '0;
      q_rd  <= '0;
      q_cnt <= '0;
    end else begin
      if (push_two) begin
        q_wr <= q_wr + QPTR_W'(2);
      end else if (push_one) begin
        q_wr <= q_wr + QPTR_W'(1);
      end
      if (pop) begin
        q_rd <= q_rd + QPTR_W'(1);
      end
      q_cnt <= q_cnt_next;
    end
  end

  assign head          = q_mem[q_rd];
  assign m_axis_tdata  = {7'd0, head.etype, head.status, head.value, head.idx};
  assign m_axis_tuser  = head.kind;
  assign m_axis_tlast  = head.last;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_cnt <= QCNT_W'(QDEPTH))
    else $error("result queue overfilled");

  a_no_field_after_error: assert property (@(posedge clk) disable iff (rst)
    (accept && error_latch != ST_OK) |-> !emit_field)
    else $error("field emitted after an error was latched");

  a_frame_cleared: assert property (@(posedge clk) disable iff (rst)
    (accept && s_axis_tlast) |=>
      (byte_count == '0 && layout_step == STEP_MAGIC && !in_text && field_count == '0))
    else $error("frame state not cleared after last byte");

  a_text_count: assert property (@(posedge clk) disable iff (rst)
    in_text |-> (text_remaining != '0))
    else $error("text body open with nothing left to count");

endmodule

`default_nettype wire

/* tb/sv/event_frame_validator_tb.sv */
module event_frame_validator_tb;
  import efv_pkg::*;

  // Event types that select a payload
  localparam logic [15:0] EV_TEXT_WORDS = 16'd1;  // text, u32, u32
  localparam logic [15:0] EV_BARE_A     = 16'd2;  // no payload
  localparam logic [15:0] EV_TEXT       = 16'd3;  // one text
  localparam logic [15:0] EV_BARE_B     = 16'd4;  // no payload
  localparam logic [15:0] EV_ACTION     = 16'd5;  // 3 u64, action, face, 3 s32, context
  localparam logic [15:0] EV_POSITION   = 16'd6;  // 3 s32, context

  localparam logic ITEM_FIELD   = 1'b0;
  localparam logic ITEM_VERDICT = 1'b1;

  localparam int ACTION_INVALID = 3;    // any action code above 2 folds to this

  // Byte offsets within a frame
  localparam int HDR_BYTES    = 48;                 // magic, version, type, 5 words
  localparam int ACTION_AT    = HDR_BYTES + 24;     // after three u64 in an action event
  localparam int TEXT_BODY_AT = HDR_BYTES + 2;      // first body byte of a text event

  localparam int RANDOM_BYTES  = 1300;
  localparam int TEXT_LEN_RAND = 6;
  localparam int STALL_LIMIT   = 2000;

  typedef enum {
    F_NONE, F_MAGIC, F_VERSION, F_TYPE, F_TEXT_LEN, F_NON_ASCII,
    F_ENUM, F_FLAG, F_TRUNCATE, F_TRAILING, F_JUNK
  } fault_t;

  typedef enum {SINK_OPEN, SINK_RANDOM, SINK_PERIODIC, SINK_SPARSE} sink_mode_t;

  typedef struct packed {
    logic        kind;
    logic [4:0]  idx;
    logic [63:0] value;
    status_t     status;
    logic [15:0] etype;
    logic        last;
  } decoded_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  event_frame_validator i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Results still owed by the block, oldest first
  decoded_t decoded_due[$];

  int n_fail     = 0;
  int n_frames   = 0;
  int n_bytes    = 0;
  int n_fields   = 0;
  int n_verdicts = 0;
  logic [15:0] codes_seen = '0;

  // ---------------------------------------------------------------------------
  // Frame decoder model: mirrors the layout walk one byte at a time
  // ---------------------------------------------------------------------------
  int          seen_bytes  = 0;
  int          step_no     = 0;
  logic [63:0] acc         = '0;
  int          acc_bytes   = 0;
  int          text_left   = 0;
  logic        body_active = 1'b0;
  logic [15:0] frame_type  = '0;
  int          action_code = 0;
  status_t     first_error = ST_OK;
  logic [4:0]  field_no    = '0;

  function automatic void layout_shape(input int s, output int nb, output kind_t kind,
                                       output int nxt);
    nb = 8; kind = K_PLAIN; nxt = s + 1;
    case (s)
      0: begin
        nb = 4; kind = K_MAGIC;
      end
      1: begin
        nb = 2; kind = K_VER;
      end
      2: begin
        nb = 2; kind = K_TYPE;
      end
      7: begin
        kind = K_DISPATCH; nxt = STEP_END;
      end
      8: begin
        nb = 2; kind = K_TEXT;
      end
      9: nb = 4;
      10: begin
        nb = 4; nxt = STEP_END;
      end
      11: begin
        nb = 2; kind = K_TEXT; nxt = STEP_END;
      end
      15: begin
        nb = 1; kind = K_ACTION;
      end
      16: begin
        nb = 1; kind = K_FACE;
      end
      17, 18, 19: begin
        nb = 4; kind = K_S32;
      end
      20, 21, 22, 23, 24: begin
        nb = 2; kind = K_TEXT;
      end
      26: begin
        nb = 1; kind = K_FLAG; nxt = STEP_END;
      end
      default: ;  // remaining steps are plain 8-byte words
    endcase
  endfunction

  // Works out what one accepted byte produces and queues it
  function automatic void validate_byte(input logic [7:0] b, input logic l);
    decoded_t    made[$];
    int          nb;
    int          nxt;
    kind_t       kind;
    logic [63:0] v;
    status_t     st;
    if (seen_bytes <= MAX_FRAME) seen_bytes++;
    if (first_error == ST_OK) begin
      if (step_no >= int'(STEP_END)) begin
        first_error = ST_TRAILING;
      end else if (body_active) begin
        if (b < 8'd32 || b > 8'd126) first_error = ST_NON_ASCII;
        text_left--;
        if (text_left == 0) body_active = 1'b0;
      end else begin
        layout_shape(step_no, nb, kind, nxt);
        acc |= 64'(b) << (8 * (acc_bytes % 8));
        acc_bytes++;
        if (acc_bytes >= nb) begin
          v = acc;
          case (kind)
            K_MAGIC: if (v != 64'(MAGIC_WORD)) first_error = ST_SCHEMA;
            K_VER: if (v != 64'd1) first_error = ST_SCHEMA;
            K_TYPE: frame_type = v[15:0];
            K_DISPATCH: begin
              case (frame_type)
                EV_TEXT_WORDS:       nxt = STEP_T1;
                EV_BARE_A, EV_BARE_B: nxt = STEP_END;
                EV_TEXT:             nxt = STEP_T3;
                EV_ACTION:           nxt = STEP_T5;
                EV_POSITION:         nxt = STEP_T6;
                default:             first_error = ST_UNK_TYPE;
              endcase
            end
            K_ACTION: action_code = (v > 64'd2) ? ACTION_INVALID : int'(v);
            K_FACE: if (action_code == ACTION_INVALID || v > 64'd5) first_error = ST_BAD_ENUM;
            K_FLAG: if (v > 64'd1) first_error = ST_BAD_FLAG;
            K_TEXT: begin
              if (v > 64'(MAX_TEXT)) begin
                first_error = ST_BAD_LEN;
              end else if (v != 64'd0) begin
                body_active = 1'b1;
                text_left   = int'(v);
              end
            end
            K_S32: v = {{32{v[31]}}, v[31:0]};
            default: ;
          endcase
          if (first_error == ST_OK) step_no = nxt;
          made.push_back('{kind: ITEM_FIELD, idx: field_no, value: v, status: ST_OK,
                           etype: 16'h0000, last: 1'b0});
          field_no++;
          acc       = '0;
          acc_bytes = 0;
        end
      end
    end else if (body_active) begin
      // body still counted after an error so a cut inside it reads as bad length
      text_left--;
      if (text_left == 0) body_active = 1'b0;
    end

    if (l) begin
      if (seen_bytes > MAX_FRAME)       st = ST_OVERSIZE;
      else if (body_active)             st = ST_BAD_LEN;
      else if (first_error != ST_OK)    st = first_error;
      else if (step_no < int'(STEP_END)) st = ST_TRUNCATED;
      else                              st = ST_OK;
      made.push_back('{kind: ITEM_VERDICT, idx: 5'd0, value: 64'd0, status: st,
                       etype: frame_type, last: 1'b0});
      seen_bytes  = 0;
      step_no     = 0;
      acc         = '0;
      acc_bytes   = 0;
      text_left   = 0;
      body_active = 1'b0;
      frame_type  = '0;
      action_code = 0;
      first_error = ST_OK;
      field_no    = '0;
    end

    if (made.size() > 0) made[made.size() - 1].last = 1'b1;
    foreach (made[i]) decoded_due.push_back(made[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: bursts of requests with random gaps between them
  // ---------------------------------------------------------------------------
  int burst_left = 0;

  task automatic send_byte(input logic [7:0] b, input logic l);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= l;
    do @(posedge clk); while (!s_axis_tready);
    validate_byte(b, l);
    burst_left--;
    n_bytes++;
  endtask

  // ---------------------------------------------------------------------------
  // Frame builder
  // ---------------------------------------------------------------------------
  logic [7:0] frame_bytes[$];
  int text_no        = 0;
  int text_target    = 0;
  int fixed_text_len = -1;   // -1: random text lengths

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return 64'd0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [31:0] rand_s32();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'hffff_ffff;
      3:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic void put_le(input logic [63:0] v, input int n);
    for (int i = 0; i < n; i++) frame_bytes.push_back(v[8*i +: 8]);
  endfunction

  function automatic void put_text(input fault_t fault);
    int   len;
    int   bad_at;
    logic hit;
    hit = (text_no == text_target);
    bad_at = -1;
    if (fault == F_TEXT_LEN && hit) len = $urandom_range(MAX_TEXT + 1, 65535);
    else if (fixed_text_len >= 0)   len = fixed_text_len;
    else                            len = $urandom_range(0, TEXT_LEN_RAND);
    if (fault == F_NON_ASCII && hit) begin
      if (len == 0) len = 1;
      bad_at = $urandom_range(0, len - 1);
    end
    put_le(64'(len), 2);
    if (len <= MAX_TEXT) begin
      for (int i = 0; i < len; i++) begin
        if (i == bad_at) begin
          // 0 or 127
          frame_bytes.push_back(8'($urandom_range(0, 160) + (($urandom_range(0, 1) == 0) ?
                                                               0 : 95)) % 8'd32 == 8'd0 ?
                                8'd127 : 8'd0);
        end else begin
          frame_bytes.push_back(8'($urandom_range(32, 126)));
        end
      end
    end
    text_no++;
  endfunction

  function automatic void put_context(input fault_t fault);
    repeat (5) put_text(fault);
    put_le(rand_word(), 8);
    put_le(64'(fault == F_FLAG ? $urandom_range(2, 255) : $urandom_range(0, 1)), 1);
  endfunction

  function automatic void resize_frame(input int n);
    while (frame_bytes.size() > n) void'(frame_bytes.pop_back());
    while (frame_bytes.size() < n) frame_bytes.push_back(8'($urandom));
  endfunction

  function automatic void build_frame(input logic [15:0] etype, input fault_t fault);
    int   v;
    int   act;
    int   face;
    frame_bytes.delete();
    text_no = 0;
    text_target = (etype == EV_ACTION || etype == EV_POSITION) ? $urandom_range(0, 4) : 0;
    if (fault == F_JUNK) begin
      repeat ($urandom_range(1, 60)) frame_bytes.push_back(8'($urandom));
      return;
    end
    put_le(64'(fault == F_MAGIC ? MAGIC_WORD ^ (32'h1 << $urandom_range(0, 31)) :
                                  MAGIC_WORD), 4);
    v = $urandom_range(0, 65534);
    if (v >= 1) v++;
    put_le(64'(fault == F_VERSION ? v : 1), 2);
    put_le(64'(etype), 2);
    repeat (5) put_le(rand_word(), 8);
    case (etype)
      EV_TEXT_WORDS: begin
        put_text(fault);
        put_le(64'($urandom), 4);
        put_le(64'(rand_s32()), 4);
      end
      EV_TEXT: put_text(fault);
      EV_ACTION: begin
        repeat (3) put_le(rand_word(), 8);
        act  = $urandom_range(0, 2);
        face = $urandom_range(0, 5);
        if (fault == F_ENUM) begin
          if ($urandom_range(0, 1) == 0) begin
            act  = $urandom_range(3, 255);
            face = $urandom_range(0, 255);
          end else begin
            face = $urandom_range(6, 255);
          end
        end
        put_le(64'(act), 1);
        put_le(64'(face), 1);
        repeat (3) put_le(64'(rand_s32()), 4);
        put_context(fault);
      end
      EV_POSITION: begin
        repeat (3) put_le(64'(rand_s32()), 4);
        put_context(fault);
      end
      default: ;
    endcase
    if (fault == F_TRUNCATE) resize_frame($urandom_range(1, frame_bytes.size() - 1));
    if (fault == F_TRAILING) repeat ($urandom_range(1, 4)) frame_bytes.push_back(8'($urandom));
  endfunction

  task automatic send_frame();
    foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    n_frames++;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern redrawn at random from four modes
  // ---------------------------------------------------------------------------
  sink_mode_t sink_mode = SINK_OPEN;
  int         sink_tick = 0;

  always @(posedge clk) begin
    sink_tick++;
    if (sink_tick % 256 == 0) sink_mode = sink_mode_t'($urandom_range(0, 3));
    case (sink_mode)
      SINK_OPEN:     m_axis_tready <= 1'b1;
      SINK_RANDOM:   m_axis_tready <= ($urandom_range(0, 3) != 0);
      SINK_PERIODIC: m_axis_tready <= (sink_tick % 7) < 4;
      default:       m_axis_tready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Result check against the oldest owed result
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    decoded_t want;
    logic     bad;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (decoded_due.size() == 0) begin
        n_fail++;
        if (n_fail <= 10)
          $display("unexpected result: kind %0d data %h last %0d",
                   m_axis_tuser, m_axis_tdata, m_axis_tlast);
      end else begin
        want = decoded_due.pop_front();
        bad = (m_axis_tuser !== want.kind) || (m_axis_tdata[4:0] !== want.idx) ||
              (m_axis_tdata[68:5] !== want.value) || (m_axis_tdata[72:69] !== want.status) ||
              (m_axis_tdata[88:73] !== want.etype) || (m_axis_tdata[95:89] !== 7'd0) ||
              (m_axis_tlast !== want.last);
        if (bad) begin
          n_fail++;
          if (n_fail <= 10) begin
            $display("mismatch: want kind %0d idx %0d value %h status %0d type %h last %0d",
                     want.kind, want.idx, want.value, want.status, want.etype, want.last);
            $display("  got kind %0d idx %0d value %h status %0d type %h pad %h last %0d",
                     m_axis_tuser, m_axis_tdata[4:0], m_axis_tdata[68:5],
                     m_axis_tdata[72:69], m_axis_tdata[88:73], m_axis_tdata[95:89],
                     m_axis_tlast);
          end
        end else if (want.kind == ITEM_VERDICT) begin
          n_verdicts++;
          codes_seen[want.status] = 1'b1;
        end else begin
          n_fields++;
        end
      end
    end
  end

  // Watchdog: too long with no request moving on either side
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: %0d results still owed", decoded_due.size());
        $display("event_frame_validator_tb NOT OK");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_event_types();
    for (int t = 1; t <= 6; t++) begin
      build_frame(16'(t), F_NONE);
      send_frame();
    end
    build_frame(EV_ACTION, F_NONE);
    send_frame();
    build_frame(EV_POSITION, F_NONE);
    send_frame();
  endtask

  task automatic test_schema_checks();
    build_frame(EV_BARE_A, F_MAGIC);
    send_frame();
    build_frame(EV_TEXT, F_VERSION);
    frame_bytes[4] = 8'h00;
    send_frame();
    build_frame(EV_BARE_B, F_VERSION);
    frame_bytes[4] = 8'hff;
    frame_bytes[5] = 8'hff;
    send_frame();
  endtask

  task automatic test_unknown_types();
    build_frame(16'd0, F_NONE);
    send_frame();
    build_frame(16'd7, F_TRAILING);
    send_frame();
    build_frame(16'hffff, F_NONE);
    resize_frame(HDR_BYTES);           // ends on the dispatch byte
    send_frame();
    build_frame(16'd9, F_NONE);
    resize_frame(40);                  // ends before the type is judged
    send_frame();
  endtask

  task automatic test_text_lengths();
    fixed_text_len = MAX_TEXT;
    build_frame(EV_TEXT, F_NONE);
    send_frame();
    fixed_text_len = MAX_TEXT + 1;
    build_frame(EV_TEXT, F_NONE);
    send_frame();
    fixed_text_len = 65535;
    build_frame(EV_TEXT_WORDS, F_NONE);
    send_frame();
    fixed_text_len = 0;
    build_frame(EV_POSITION, F_NONE);
    send_frame();
    fixed_text_len = 10;
    build_frame(EV_TEXT, F_NONE);
    resize_frame(TEXT_BODY_AT + 4);    // cut inside the body
    send_frame();
    build_frame(EV_TEXT, F_NONE);
    resize_frame(TEXT_BODY_AT);        // cut right after the length prefix
    send_frame();
    fixed_text_len = -1;
  endtask

  task automatic test_non_ascii();
    logic [7:0] bad_chars[4];
    bad_chars = '{8'd0, 8'd31, 8'd127, 8'd255};
    fixed_text_len = 4;
    foreach (bad_chars[i]) begin
      build_frame(EV_TEXT, F_NONE);
      frame_bytes[TEXT_BODY_AT] = bad_chars[i];
      send_frame();
    end
    // a bad character followed by a cut body still reads as bad length
    build_frame(EV_TEXT, F_NONE);
    frame_bytes[TEXT_BODY_AT] = 8'h80;
    resize_frame(TEXT_BODY_AT + 2);
    send_frame();
    build_frame(EV_POSITION, F_NON_ASCII);
    send_frame();
    fixed_text_len = -1;
  endtask

  task automatic test_enum_and_flag();
    logic [7:0] act[5];
    logic [7:0] face[5];
    act  = '{8'd3, 8'd2, 8'd255, 8'd2, 8'd0};
    face = '{8'd0, 8'd6, 8'd255, 8'd5, 8'd0};
    fixed_text_len = 1;
    foreach (act[i]) begin
      build_frame(EV_ACTION, F_NONE);
      frame_bytes[ACTION_AT]     = act[i];
      frame_bytes[ACTION_AT + 1] = face[i];
      send_frame();
    end
    // the flag is the last byte of the context
    build_frame(EV_POSITION, F_NONE);
    frame_bytes[frame_bytes.size() - 1] = 8'd2;
    send_frame();
    build_frame(EV_ACTION, F_NONE);
    frame_bytes[frame_bytes.size() - 1] = 8'd255;
    send_frame();
    build_frame(EV_POSITION, F_NONE);
    frame_bytes[frame_bytes.size() - 1] = 8'd1;
    send_frame();
    fixed_text_len = -1;
  endtask

  task automatic test_truncation();
    build_frame(EV_BARE_A, F_NONE);
    resize_frame(1);
    send_frame();
    build_frame(EV_BARE_A, F_NONE);
    resize_frame(3);
    send_frame();
    build_frame(EV_POSITION, F_NONE);
    resize_frame(HDR_BYTES + 6);       // mid position word
    send_frame();
  endtask

  task automatic test_trailing();
    build_frame(EV_BARE_A, F_NONE);
    frame_bytes.push_back(8'h00);
    send_frame();
    build_frame(EV_BARE_B, F_TRAILING);
    send_frame();
  endtask

  task automatic test_oversize();
    fixed_text_len = MAX_TEXT;
    build_frame(EV_TEXT, F_NONE);
    resize_frame(MAX_FRAME);           // at the limit: trailing, not oversize
    send_frame();
    build_frame(EV_TEXT, F_NONE);
    resize_frame(MAX_FRAME + 1);
    send_frame();
    fixed_text_len = -1;
    build_frame(EV_ACTION, F_MAGIC);
    resize_frame(MAX_FRAME + 8);       // oversize wins over a latched error
    send_frame();
  endtask

  task automatic test_random_frames();
    int          first;
    int          r;
    fault_t      f;
    logic [15:0] t;
    first = n_bytes;
    while (n_bytes - first < RANDOM_BYTES) begin
      r = $urandom_range(0, 19);
      f = (r < 9) ? F_NONE : (r == 19) ? F_TRUNCATE : fault_t'(r - 8);
      case (f)
        F_TYPE: t = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom_range(7, 65535));
        F_TEXT_LEN, F_NON_ASCII: begin
          case ($urandom_range(0, 3))
            0:       t = EV_TEXT_WORDS;
            1:       t = EV_TEXT;
            2:       t = EV_ACTION;
            default: t = EV_POSITION;
          endcase
        end
        F_ENUM: t = EV_ACTION;
        F_FLAG: t = ($urandom_range(0, 1) == 0) ? EV_ACTION : EV_POSITION;
        default: t = 16'($urandom_range(1, 6));
      endcase
      build_frame(t, f);
      send_frame();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_event_types();
    test_schema_checks();
    test_unknown_types();
    test_text_lengths();
    test_non_ascii();
    test_enum_and_flag();
    test_truncation();
    test_trailing();
    test_oversize();
    test_random_frames();

    s_axis_tvalid <= 1'b0;
    while (decoded_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d frames, %0d bytes sent; %0d fields and %0d verdicts checked",
             n_frames, n_bytes, n_fields, n_verdicts);
    $display("verdict codes seen (one bit per code): %b", codes_seen);
    if (n_fail == 0) begin
      $display("event_frame_validator_tb OK");
    end else begin
      $display("%0d failures", n_fail);
      $display("event_frame_validator_tb NOT OK");
    end
    $finish;
  end

endmodule
